// ===== design/sprite_overlay_engine_macros.svh =====
// Assertion macros for the sprite overlay engine checker.
// Depends on nothing; included by the checker file.
`ifndef SPRITE_OVERLAY_ENGINE_MACROS_SVH
`define SPRITE_OVERLAY_ENGINE_MACROS_SVH

// same-cycle implication, gated by reset
`define SOE_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("sprite overlay check failed");

// next-cycle implication, gated by reset
`define SOE_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("sprite overlay check failed");

`endif

// ===== design/soe_pkg.sv =====
// Shared types, constants and helpers of the sprite overlay engine.
// No dependencies; imported by every module of the block but soe_fifo.
package soe_pkg;

  localparam int SPRITE_RAM_BYTES_DFLT  = 4096;
  localparam int PALETTE_RAM_BYTES_DFLT = 2048;
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  localparam int ADDR_W = 18;
  localparam int IDX_W  = 16;
  localparam int DIM_W  = 12;
  localparam int PROD_W = 28;
  localparam int COLS   = 8;

  localparam int PAL_BASE  = 'h10000;
  localparam int CTRL_BASE = 'h30000;
  localparam int CTRL_END  = 'h30020;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_RENDER = 2'd2;

  localparam logic [1:0] REG_ON    = 2'd0;
  localparam logic [1:0] REG_OUT_W = 2'd1;
  localparam logic [1:0] REG_OUT_H = 2'd2;
  localparam logic [1:0] REG_SRC_W = 2'd3;

  localparam logic [7:0] GHOST_TAG = 8'hbc;

  typedef enum logic [1:0] {
    OP_READ, OP_WRITE, OP_RENDER, OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    TG_NONE, TG_SPR, TG_PAL, TG_CTRL0, TG_CTRLEN, TG_CTRLX
  } tgt_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [17:0] address;
    logic [31:0] write_data;
    logic [31:0] byte_mask;
    logic [8:0]  entry;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        draw;
    logic [11:0] pixel_row;
    logic [11:0] span_start;
    logic [11:0] span_end;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } res_t;

  typedef struct packed {
    op_t              op;
    tgt_t             tgt;
    logic [IDX_W-1:0] idx;
    logic [31:0]      wdata;
    logic [31:0]      mask;
    logic [8:0]       entry;
  } cmd_t;

  typedef struct packed {
    logic             overlay_on;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic [DIM_W-1:0] src_cols;
  } cfg_t;

  localparam res_t RES_DONE = '{read_data: 32'd0, draw: 1'b0, pixel_row: 12'd0,
                                span_start: 12'd0, span_end: 12'd0, red: 8'd0,
                                green: 8'd0, blue: 8'd0, last: 1'b1};

  localparam logic [3:0] BLOCK_SHADE [64] = '{
    4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4, 4'd3,
    4'd9, 4'd7, 4'd5, 4'd6, 4'd4, 4'd1, 4'd1, 4'd4,
    4'd9, 4'd8, 4'd6, 4'd5, 4'd1, 4'd1, 4'd1, 4'd5,
    4'd9, 4'd8, 4'd7, 4'd5, 4'd1, 4'd1, 4'd4, 4'd6,
    4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6,
    4'd9, 4'd8, 4'd6, 4'd7, 4'd7, 4'd6, 4'd5, 4'd6,
    4'd9, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7, 4'd6,
    4'd8, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd8
  };

  localparam logic [3:0] SEP_SHADE [8] = '{
    4'he, 4'hd, 4'h0, 4'h0, 4'h0, 4'hd, 4'he, 4'hf
  };

  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

// ===== design/soe_fifo.sv =====
// Small register queue, used between front and back and on the result side.
// Depends on nothing; DEPTH is a power of two of at least two.
module soe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= wdata;
  end
endmodule

// ===== design/soe_front.sv =====
// Front end: accepts items and classifies them into back-end commands.
// Depends on soe_pkg.
module soe_front #(
  parameter int SPRITE_RAM_BYTES  = soe_pkg::SPRITE_RAM_BYTES_DFLT,
  parameter int PALETTE_RAM_BYTES = soe_pkg::PALETTE_RAM_BYTES_DFLT
) (
  input  soe_pkg::in_t  in_item,
  input  logic          push,
  output logic          full,
  input  logic          cmd_full,
  input  logic          clearing,
  output logic          cmd_push,
  output soe_pkg::cmd_t cmd
);
  import soe_pkg::*;

  localparam int SPR_AW  = $clog2(SPRITE_RAM_BYTES / 4);
  localparam int PAL_AW  = $clog2(PALETTE_RAM_BYTES / 4);
  localparam int PAL_END = PAL_BASE + PALETTE_RAM_BYTES;

  logic [ADDR_W-1:0] addr;
  logic spr_hit, pal_hit, ctrl_hit;

  assign full     = cmd_full || clearing;
  assign cmd_push = push && !full;
  assign addr     = in_item.address;
  assign spr_hit  = addr < ADDR_W'(SPRITE_RAM_BYTES);
  assign pal_hit  = (addr >= ADDR_W'(PAL_BASE)) && (addr < ADDR_W'(PAL_END));
  assign ctrl_hit = (addr >= ADDR_W'(CTRL_BASE)) && (addr < ADDR_W'(CTRL_END));

  always_comb begin
    case (in_item.mode)
      MODE_READ:   cmd.op = OP_READ;
      MODE_WRITE:  cmd.op = OP_WRITE;
      MODE_RENDER: cmd.op = OP_RENDER;
      default:     cmd.op = OP_NONE;
    endcase
    if (spr_hit) begin
      cmd.tgt = TG_SPR;
    end else if (pal_hit) begin
      cmd.tgt = TG_PAL;
    end else if (ctrl_hit) begin
      if (addr[4:2] == 3'b000) cmd.tgt = TG_CTRL0;
      else if (addr[4:2] == 3'b111) cmd.tgt = TG_CTRLEN;
      else cmd.tgt = TG_CTRLX;
    end else begin
      cmd.tgt = TG_NONE;
    end
    cmd.idx   = spr_hit ? IDX_W'(addr[SPR_AW+1:2]) : IDX_W'(addr[PAL_AW+1:2]);
    cmd.wdata = in_item.write_data;
    cmd.mask  = in_item.byte_mask;
    cmd.entry = in_item.entry;
  end
endmodule

// ===== design/soe_div.sv =====
// Radix-2 restoring divider, signed numerator over unsigned divisor,
// quotient truncated toward zero. Depends on soe_pkg.
module soe_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [soe_pkg::PROD_W-1:0]  num,
  input  logic [soe_pkg::DIM_W-1:0]          den,
  output logic                               done,
  output logic signed [soe_pkg::PROD_W-1:0]  quo
);
  import soe_pkg::*;

  localparam int MAG_W = PROD_W - 1;
  localparam int CNT_W = $clog2(MAG_W);

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] mag_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIM_W:0]   rem_sh;
  logic             ge;
  logic [PROD_W-1:0] num_abs, q_mag;

  assign num_abs = num[PROD_W-1] ? (~num + 1'b1) : num;
  assign rem_sh  = {rem_r, mag_r[MAG_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign q_mag   = {1'b0, mag_r};
  assign quo     = neg_r ? (~q_mag + 1'b1) : q_mag;
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= num_abs[MAG_W-1:0];
      neg_r <= num[PROD_W-1];
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DIM_W'(rem_sh - {1'b0, den}) : rem_sh[DIM_W-1:0];
      mag_r <= {mag_r[MAG_W-2:0], ge};
    end
  end
endmodule

// ===== design/soe_back.sv =====
// Back end: sprite and palette RAMs, bus accesses and the block renderer.
// Depends on soe_pkg and soe_div.
module soe_back #(
  parameter int SPRITE_RAM_BYTES  = soe_pkg::SPRITE_RAM_BYTES_DFLT,
  parameter int PALETTE_RAM_BYTES = soe_pkg::PALETTE_RAM_BYTES_DFLT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  soe_pkg::cfg_t cfg,
  input  soe_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output soe_pkg::res_t res,
  output logic          clearing
);
  import soe_pkg::*;

  localparam int SPR_WORDS = SPRITE_RAM_BYTES / 4;
  localparam int PAL_WORDS = PALETTE_RAM_BYTES / 4;
  localparam int SPR_AW    = $clog2(SPR_WORDS);
  localparam int PAL_AW    = $clog2(PAL_WORDS);
  localparam int CLR_W     = (SPR_AW > PAL_AW) ? SPR_AW : PAL_AW;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_READ   = 12'b0000_0000_0100,
    S_WRITE  = 12'b0000_0000_1000,
    S_FETCH0 = 12'b0000_0001_0000,
    S_FETCH1 = 12'b0000_0010_0000,
    S_MUL    = 12'b0000_0100_0000,
    S_DIVS   = 12'b0000_1000_0000,
    S_DIVW   = 12'b0001_0000_0000,
    S_PIX    = 12'b0010_0000_0000,
    S_PIXO   = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] spr_mem [SPR_WORDS];
  logic [31:0] pal_mem [PAL_WORDS];
  logic [31:0] spr_q_r, pal_q_r;
  logic [SPR_AW-1:0] spr_raddr, spr_waddr, head_i0, cur_i0;
  logic [PAL_AW-1:0] pal_raddr, pal_waddr;
  logic [SPR_AW+9:0] head_e, cur_e;
  logic        spr_we, pal_we;
  logic [31:0] spr_wdata, pal_wdata;

  logic [CLR_W-1:0] clr_r;
  logic        en_r, pend_v_r;
  cmd_t        cmd_r;
  res_t        res_r, res_new;
  logic [7:0]  attr_r;
  logic [14:0] x_r;
  logic [7:0]  y8_r;
  logic [5:0]  pal_r;
  logic        empty_r;
  logic [3:0]  k_r;
  logic [5:0]  pix_r;
  logic signed [PROD_W-1:0] prod_r, q_prev_r;
  logic [DIM_W-1:0] span_s_r [COLS];
  logic [DIM_W-1:0] span_e_r [COLS];
  logic             span_ok_r [COLS];

  logic        render_ok, div_start, div_done, emit, last_pix, pixo_go;
  logic signed [PROD_W-1:0] div_quo, e_fix, s_cl, e_cl, wl;
  logic [15:0] sx;
  logic signed [28:0] prod_full;
  logic [2:0]  xi, yi;
  logic [11:0] row;
  logic [3:0]  shade;
  logic [9:0]  po;
  logic [15:0] raw;
  logic [31:0] rd_sel;

  soe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (cfg.src_cols),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign clearing  = (state_r == S_CLEAR);
  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty;
  assign div_start = (state_r == S_DIVS);
  assign render_ok = cfg.overlay_on && en_r && (|cfg.out_width) && (|cfg.out_height)
                     && (|cfg.src_cols);
  assign res       = res_r;

  // block entry index, wrapped to the sprite RAM depth
  assign head_e  = {{SPR_AW{1'b0}}, cmd.entry, 1'b0};
  assign cur_e   = {{SPR_AW{1'b0}}, cmd_r.entry, 1'b0};
  assign head_i0 = head_e[SPR_AW-1:0];
  assign cur_i0  = cur_e[SPR_AW-1:0];

  // pixel walk
  assign xi       = pix_r[2:0];
  assign yi       = pix_r[5:3];
  assign last_pix = &pix_r;
  assign row      = 12'(y8_r) + 12'(yi) + 12'd7;
  assign shade    = empty_r ? SEP_SHADE[xi] : BLOCK_SHADE[pix_r];
  assign po       = {pal_r, shade};
  assign emit     = (row < cfg.out_height) && !(empty_r && (SEP_SHADE[xi] == 4'd0))
                    && span_ok_r[xi];
  assign pixo_go  = !(pend_v_r && res_full);
  assign raw      = po[0] ? pal_q_r[15:0] : pal_q_r[31:16];

  assign res_push = ((state_r == S_EMIT) && !res_full)
                    || ((state_r == S_PIXO) && pend_v_r && !res_full);

  // column scaling
  assign sx        = {x_r[14], x_r} + 16'(k_r) + 16'd4;
  assign prod_full = $signed(sx) * $signed({1'b0, cfg.out_width});
  assign wl        = $signed({{(PROD_W-DIM_W){1'b0}}, cfg.out_width});
  assign e_fix     = (div_quo <= q_prev_r) ? (q_prev_r + 28'sd1) : div_quo;
  assign s_cl      = (q_prev_r < 0) ? '0 : q_prev_r;
  assign e_cl      = (e_fix > wl) ? wl : e_fix;

  always_comb begin
    res_new            = RES_DONE;
    res_new.draw       = 1'b1;
    res_new.pixel_row  = row;
    res_new.span_start = span_s_r[xi];
    res_new.span_end   = span_e_r[xi];
    res_new.red        = expand5(raw[4:0]);
    res_new.green      = expand5(raw[9:5]);
    res_new.blue       = expand5(raw[14:10]);
    res_new.last       = last_pix;
  end

  always_comb begin
    case (cmd_r.tgt)
      TG_SPR:   rd_sel = spr_q_r;
      TG_PAL:   rd_sel = pal_q_r;
      TG_CTRL0: rd_sel = {15'd0, !en_r, 16'd0};
      default:  rd_sel = 32'hffff_ffff;
    endcase
  end

  // memory ports
  always_comb begin
    spr_raddr = (state_r == S_IDLE) ? ((cmd.op == OP_RENDER) ? head_i0 : cmd.idx[SPR_AW-1:0])
                                    : cur_i0 + 1'b1;
    pal_raddr = (state_r == S_IDLE) ? cmd.idx[PAL_AW-1:0] : PAL_AW'(po[9:1]);
    spr_waddr = clearing ? clr_r[SPR_AW-1:0] : cmd_r.idx[SPR_AW-1:0];
    pal_waddr = clearing ? clr_r[PAL_AW-1:0] : cmd_r.idx[PAL_AW-1:0];
    spr_we    = clearing || ((state_r == S_WRITE) && (cmd_r.tgt == TG_SPR));
    pal_we    = clearing || ((state_r == S_WRITE) && (cmd_r.tgt == TG_PAL));
    spr_wdata = clearing ? '0 : ((spr_q_r & ~cmd_r.mask) | (cmd_r.wdata & cmd_r.mask));
    pal_wdata = clearing ? '0 : ((pal_q_r & ~cmd_r.mask) | (cmd_r.wdata & cmd_r.mask));
  end

  always_ff @(posedge clk) begin
    if (spr_we) spr_mem[spr_waddr] <= spr_wdata;
    spr_q_r <= spr_mem[spr_raddr];
  end

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
    pal_q_r <= pal_mem[pal_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (&clr_r) state_nxt = S_IDLE;
      S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            OP_READ:   state_nxt = S_READ;
            OP_WRITE:  state_nxt = S_WRITE;
            OP_RENDER: state_nxt = render_ok ? S_FETCH0 : S_EMIT;
            default:   state_nxt = S_EMIT;
          endcase
        end
      end
      S_READ:   state_nxt = S_EMIT;
      S_WRITE:  state_nxt = S_EMIT;
      S_FETCH0: state_nxt = S_FETCH1;
      S_FETCH1: state_nxt = S_MUL;
      S_MUL:    state_nxt = S_DIVS;
      S_DIVS:   state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) state_nxt = (k_r == 4'(COLS)) ? S_PIX : S_MUL;
      end
      S_PIX: begin
        if (emit) state_nxt = S_PIXO;
        else if (last_pix) state_nxt = S_EMIT;
      end
      S_PIXO: if (pixo_go) state_nxt = last_pix ? S_EMIT : S_PIX;
      S_EMIT: if (!res_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      en_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if ((state_r == S_WRITE) && (cmd_r.tgt == TG_CTRLEN)) en_r <= cmd_r.wdata[0];
      if (state_r == S_DIVW) pend_v_r <= 1'b0;
      else if ((state_r == S_PIXO) && pixo_go) pend_v_r <= 1'b1;
      else if ((state_r == S_EMIT) && !res_full) pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd;
    case (state_r)
      S_IDLE:   res_r <= RES_DONE;
      S_READ:   res_r.read_data <= rd_sel;
      S_FETCH0: attr_r <= spr_q_r[7:0];
      S_FETCH1: begin
        x_r     <= spr_q_r[31:17];
        y8_r    <= spr_q_r[7:0];
        pal_r   <= {(spr_q_r[15:8] == GHOST_TAG), 1'b0, attr_r[7:6], attr_r[2:1]};
        empty_r <= attr_r[5];
        k_r     <= '0;
      end
      S_MUL: prod_r <= prod_full[PROD_W-1:0];
      S_DIVW: begin
        if (div_done) begin
          q_prev_r <= div_quo;
          k_r      <= k_r + 1'b1;
          pix_r    <= '0;
          // end of this column is the start of the next one
          if (k_r != 4'd0) begin
            span_s_r[3'(k_r - 4'd1)]  <= s_cl[DIM_W-1:0];
            span_e_r[3'(k_r - 4'd1)]  <= e_cl[DIM_W-1:0];
            span_ok_r[3'(k_r - 4'd1)] <= s_cl < e_cl;
          end
        end
      end
      S_PIX: begin
        if (!emit) begin
          if (!last_pix) pix_r <= pix_r + 1'b1;
          else if (pend_v_r) res_r.last <= 1'b1;
        end
      end
      S_PIXO: begin
        if (pixo_go) begin
          res_r <= res_new;
          if (!last_pix) pix_r <= pix_r + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== design/sprite_overlay_engine.sv =====
// Sprite overlay engine. Bus read/write: accepted items wait in the command queue
// while the back end handles one item at a time; results leave through the result
// queue. Render: fetch states FETCH0 and FETCH1, 9 column divisions in the shared
// divider, then a pixel walk with one span per drawn pixel, held while the result
// queue is full; a disabled render gives the done item only. After reset a clearing
// pass zeroes both RAMs; full stays high meanwhile.
module sprite_overlay_engine #(
  parameter int SPRITE_RAM_BYTES  = soe_pkg::SPRITE_RAM_BYTES_DFLT,
  parameter int PALETTE_RAM_BYTES = soe_pkg::PALETTE_RAM_BYTES_DFLT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  soe_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output soe_pkg::res_t out_item,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import soe_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd_in, cmd_out;
  res_t res_in;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full, clearing, cfg_wr;
  logic [$bits(cmd_t)-1:0] cmd_rdata;
  logic [$bits(res_t)-1:0] res_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cmd_out = cmd_t'(cmd_rdata);
  assign out_item = res_t'(res_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overlay_on <= 1'b0;
      cfg_r.out_width  <= 12'd640;
      cfg_r.out_height <= 12'd480;
      cfg_r.src_cols   <= 12'd320;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ON:    cfg_r.overlay_on <= pwdata[0];
        REG_OUT_W: cfg_r.out_width  <= pwdata[DIM_W-1:0];
        REG_OUT_H: cfg_r.out_height <= pwdata[DIM_W-1:0];
        REG_SRC_W: cfg_r.src_cols   <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ON:    prdata = {31'd0, cfg_r.overlay_on};
      REG_OUT_W: prdata = 32'(cfg_r.out_width);
      REG_OUT_H: prdata = 32'(cfg_r.out_height);
      REG_SRC_W: prdata = 32'(cfg_r.src_cols);
      default:   prdata = '0;
    endcase
  end

  soe_front #(
    .SPRITE_RAM_BYTES  (SPRITE_RAM_BYTES),
    .PALETTE_RAM_BYTES (PALETTE_RAM_BYTES)
  ) u_front (
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .cmd_full (cmd_full),
    .clearing (clearing),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  soe_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  soe_back #(
    .SPRITE_RAM_BYTES  (SPRITE_RAM_BYTES),
    .PALETTE_RAM_BYTES (PALETTE_RAM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  soe_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );
endmodule

// ===== design/soe_checker.sv =====
// Port-level checks of the sprite overlay engine, bound to the top level.
// Depends on soe_pkg and sprite_overlay_engine_macros.svh.
`include "sprite_overlay_engine_macros.svh"

module soe_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input soe_pkg::res_t out_item
);
  import soe_pkg::*;

  // clearing pass holds off input right after reset
  `SOE_ASSERT_IMP(a_full_after_rst, clk, rst_n, !$past(rst_n), full)
  `SOE_ASSERT_IMP(a_empty_after_rst, clk, rst_n, !$past(rst_n), empty)
  `SOE_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item))
  `SOE_ASSERT_IMP(a_nodraw_clean, clk, rst_n, !empty && !out_item.draw, out_item.pixel_row == 12'd0 && out_item.span_start == 12'd0 && out_item.span_end == 12'd0 && out_item.red == 8'd0 && out_item.green == 8'd0 && out_item.blue == 8'd0 && out_item.last)
  `SOE_ASSERT_IMP(a_span_order, clk, rst_n, !empty && out_item.draw, out_item.read_data == 32'd0 && out_item.span_start < out_item.span_end)
endmodule

bind sprite_overlay_engine soe_checker u_soe_checker (.*);

// ===== test/sprite_overlay_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sprite_overlay_engine: bus reads, masked writes and block renders.
// Depends on soe_pkg and the sprite_overlay_engine RTL.
// Results are checked against a local span predictor.
module sprite_overlay_engine_tb;
  import soe_pkg::*;

  localparam int  SPR_WORDS   = 1024;
  localparam int  PAL_WORDS   = 512;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  SETTLE      = 500;

  logic        clk, rst_n, push, full, empty, pop;
  in_t         in_item;
  res_t        out_item;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  sprite_overlay_engine i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the chip state and registers
  logic [31:0] spr_mem [SPR_WORDS];
  logic [31:0] pal_mem [PAL_WORDS];
  logic        ovl_enable;
  logic        ovl_on;
  logic [11:0] frame_w, frame_h, source_w;

  res_t  pending_spans[$];
  int    fail_count;
  int    cycle_count;
  int    send_idle_pct, pop_stall_pct;

  typedef struct {
    in_t  item;
    bit   typed;
    res_t want;
  } row_t;
  row_t vectors[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sprite_overlay_engine: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] chan8(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [31:0] bus_peek(input logic [17:0] off);
    if (off < 18'h1000) return spr_mem[off[11:2]];
    if (off >= PAL_BASE && off < PAL_BASE + 'h800) return pal_mem[off[10:2]];
    if (off >= CTRL_BASE && off < CTRL_END)
      return (off[4:2] == 3'd0) ? {15'd0, ~ovl_enable, 16'd0} : 32'hffffffff;
    return 32'hffffffff;
  endfunction

  task automatic bus_poke(input logic [17:0] off, input logic [31:0] val,
                          input logic [31:0] mask);
    if (off < 18'h1000)
      spr_mem[off[11:2]] = (spr_mem[off[11:2]] & ~mask) | (val & mask);
    else if (off >= PAL_BASE && off < PAL_BASE + 'h800)
      pal_mem[off[10:2]] = (pal_mem[off[10:2]] & ~mask) | (val & mask);
    else if (off >= CTRL_BASE && off < CTRL_END && off[4:2] == 3'd7)
      ovl_enable = val[0];
  endtask

  task automatic render_spans(input logic [8:0] entry);
    logic [9:0]  i0;
    logic [15:0] attr, yraw;
    logic [31:0] w1, raw;
    logic [5:0]  pal;
    logic [3:0]  shade;
    logic [9:0]  po;
    logic        is_empty;
    int          x, y8, ry, n;
    longint      sx, s, e;
    res_t        r;
    n = 0;
    if (!ovl_on || !ovl_enable || frame_w == 0 || frame_h == 0 || source_w == 0) return;
    i0 = {entry, 1'b0};
    attr = spr_mem[i0][15:0];
    w1 = spr_mem[i0 + 10'd1];
    is_empty = attr[5];
    x = int'(signed'(w1[31:16]));
    x = (x < 0) ? (x - 1) / 2 : x / 2;
    yraw = w1[15:0];
    y8 = yraw[7:0];
    pal = {(yraw[15:8] == GHOST_TAG), 1'b0, attr[7:6], attr[2:1]};
    for (int yi = 0; yi < 8; yi++) begin
      ry = y8 + yi + 7;
      if (ry >= frame_h) continue;
      for (int xi = 0; xi < 8; xi++) begin
        if (is_empty && SEP_SHADE[xi] == 4'd0) continue;
        shade = is_empty ? SEP_SHADE[xi] : BLOCK_SHADE[xi + yi * 8];
        po = pal * 16 + shade;
        raw = pal_mem[po[9:1]] >> (po[0] ? 0 : 16);
        sx = x + xi + 4;
        s = sx * longint'(frame_w) / longint'(source_w);
        e = (sx + 1) * longint'(frame_w) / longint'(source_w);
        if (e <= s) e = s + 1;
        if (s < 0) s = 0;
        if (e > longint'(frame_w)) e = longint'(frame_w);
        if (s >= e || n >= 64) continue;
        r = '{read_data: 32'd0, draw: 1'b1, pixel_row: ry[11:0], span_start: s[11:0],
              span_end: e[11:0], red: chan8(raw[4:0]), green: chan8(raw[9:5]),
              blue: chan8(raw[14:10]), last: 1'b0};
        pending_spans.push_back(r);
        n++;
      end
    end
    if (n > 0) pending_spans[pending_spans.size() - 1].last = 1'b1;
  endtask

  task automatic predict_item(input in_t it);
    res_t r;
    int   before_n;
    r = RES_DONE;
    case (it.mode)
      MODE_READ: begin
        r.read_data = bus_peek(it.address);
        pending_spans.push_back(r);
      end
      MODE_WRITE: begin
        bus_poke(it.address, it.write_data, it.byte_mask);
        pending_spans.push_back(r);
      end
      MODE_RENDER: begin
        before_n = pending_spans.size();
        render_spans(it.entry);
        if (pending_spans.size() == before_n) pending_spans.push_back(r);
      end
      default: pending_spans.push_back(r);
    endcase
  endtask

  // hold push high after an accept so the next item can follow directly
  task automatic send_item(input in_t it, input bit typed = 0, input res_t want = RES_DONE);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        push = 1'b0;
      end else begin
        push = 1'b1;
        in_item = it;
        @(posedge clk);
        if (!full) begin
          done = 1;
          if (typed) begin
            if (it.mode == MODE_WRITE) bus_poke(it.address, it.write_data, it.byte_mask);
            pending_spans.push_back(want);
          end else begin
            predict_item(it);
          end
        end
      end
    end
  endtask

  function automatic in_t mk(input logic [1:0] mode, input logic [17:0] addr,
                             input logic [31:0] wd, input logic [31:0] mask,
                             input logic [8:0] entry);
    in_t it;
    it.mode = mode; it.address = addr; it.write_data = wd;
    it.byte_mask = mask; it.entry = entry;
    return it;
  endfunction

  task automatic check_span(input res_t want, input res_t got);
    if (got.read_data !== want.read_data) begin
      $error("read_data exp %h got %h", want.read_data, got.read_data); fail_count++;
    end
    if (got.draw !== want.draw) begin
      $error("draw exp %0d got %0d", want.draw, got.draw); fail_count++;
    end
    if (got.pixel_row !== want.pixel_row) begin
      $error("pixel_row exp %0d got %0d", want.pixel_row, got.pixel_row); fail_count++;
    end
    if (got.span_start !== want.span_start) begin
      $error("span_start exp %0d got %0d", want.span_start, got.span_start); fail_count++;
    end
    if (got.span_end !== want.span_end) begin
      $error("span_end exp %0d got %0d", want.span_end, got.span_end); fail_count++;
    end
    if (got.red !== want.red) begin
      $error("red exp %h got %h", want.red, got.red); fail_count++;
    end
    if (got.green !== want.green) begin
      $error("green exp %h got %h", want.green, got.green); fail_count++;
    end
    if (got.blue !== want.blue) begin
      $error("blue exp %h got %h", want.blue, got.blue); fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last exp %0d got %0d", want.last, got.last); fail_count++;
    end
  endtask

  // result side: random stalls, compare with the oldest expectation
  always begin
    @(negedge clk);
    pop = ($urandom_range(99) >= pop_stall_pct);
    @(posedge clk);
    if (rst_n && pop && !empty) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected item: %p", out_item);
        fail_count++;
      end else begin
        check_span(pending_spans.pop_front(), out_item);
      end
    end
  end

  task automatic drain;
    @(negedge clk);
    push = 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_ON:    ovl_on = val[0];
      REG_OUT_W: frame_w = val[11:0];
      REG_OUT_H: frame_h = val[11:0];
      default:   source_w = val[11:0];
    endcase
  endtask

  task automatic set_frame(input logic on, input int ow, input int oh, input int sw);
    drain();
    reg_write(REG_ON, on);
    reg_write(REG_OUT_W, ow);
    reg_write(REG_OUT_H, oh);
    reg_write(REG_SRC_W, sw);
  endtask

  // well-formed block: attr word, position word, some palette, sometimes the enable word, then render
  task automatic block_sequence;
    logic [8:0]  entry;
    logic [15:0] xpos, ypos;
    entry = 9'($urandom_range(511));
    send_item(mk(MODE_WRITE, {5'd0, entry, 3'd0}, $urandom,
                 ($urandom_range(3) == 0) ? $urandom : 32'hffffffff, 9'($urandom)));
    xpos = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(80)) - 20);
    ypos = {($urandom_range(3) == 0) ? GHOST_TAG : 8'($urandom), 8'($urandom)};
    send_item(mk(MODE_WRITE, {5'd0, entry, 3'd4}, {xpos, ypos}, 32'hffffffff,
                 9'($urandom)));
    repeat ($urandom_range(2))
      send_item(mk(MODE_WRITE, 18'(PAL_BASE) + 18'($urandom_range(511) * 4), $urandom,
                   $urandom, 9'($urandom)));
    if ($urandom_range(7) == 0)
      send_item(mk(MODE_WRITE, 18'h3001c, 32'($urandom_range(7) != 0), $urandom,
                   9'($urandom)));
    send_item(mk(MODE_RENDER, 18'($urandom), $urandom, $urandom, entry));
  endtask

  task automatic random_phase(input int count);
    int sent;
    in_t it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 7) begin
        block_sequence();
        sent += 4;
      end else begin
        it = in_t'({$urandom, $urandom, $urandom});
        // steer some noise onto the mapped regions
        case ($urandom_range(3))
          0: it.address = {6'd0, 12'($urandom)};
          1: it.address = 18'(PAL_BASE) + 18'($urandom_range(2047));
          2: it.address = 18'(CTRL_BASE) + 18'($urandom_range(31));
          default: ;
        endcase
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0; push = 1'b0; pop = 1'b0; in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    fail_count = 0; cycle_count = 0; send_idle_pct = 0; pop_stall_pct = 0;
    foreach (spr_mem[i]) spr_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    ovl_enable = 1'b0; ovl_on = 1'b0; frame_w = 640; frame_h = 480; source_w = 320;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    reg_write(REG_ON, 1);
    vectors = '{
      '{mk(MODE_READ, 18'h0, 0, 0, 0), 1, '{32'h0, 0, 0, 0, 0, 0, 0, 0, 1}},
      '{mk(MODE_READ, 18'h3ffff, 0, 0, 0), 1, '{32'hffffffff, 0, 0, 0, 0, 0, 0, 0, 1}},
      '{mk(MODE_READ, 18'h30000, 0, 0, 0), 1, '{32'h00010000, 0, 0, 0, 0, 0, 0, 0, 1}},
      '{mk(MODE_READ, 18'h30004, 0, 0, 0), 1, '{32'hffffffff, 0, 0, 0, 0, 0, 0, 0, 1}},
      '{mk(OP_NONE, 18'h3ffff, '1, '1, '1), 1, RES_DONE},
      '{mk(MODE_RENDER, 0, 0, 0, 9'h1ff), 1, RES_DONE},
      '{mk(MODE_WRITE, 18'h3001c, 32'h1, 32'h0, 0), 1, RES_DONE},
      '{mk(MODE_READ, 18'h30000, 0, 0, 0), 1, '{32'h0, 0, 0, 0, 0, 0, 0, 0, 1}},
      '{mk(MODE_WRITE, 18'h30000, 32'h0, '1, 0), 1, RES_DONE},
      '{mk(MODE_WRITE, 18'h0, 32'h000000c6, '1, 0), 1, RES_DONE},
      '{mk(MODE_WRITE, 18'h4, 32'hfff00010, '1, 0), 1, RES_DONE},
      '{mk(MODE_WRITE, 18'h107fc, '1, '1, 0), 1, RES_DONE},
      '{mk(MODE_WRITE, 18'h10000, 32'h7fff7fff, 32'h0000ffff, 0), 1, RES_DONE},
      '{mk(MODE_WRITE, 18'h10064, 32'h12345678, '1, 0), 1, RES_DONE},
      '{mk(MODE_RENDER, 0, 0, 0, 9'd0), 0, RES_DONE},
      '{mk(MODE_WRITE, 18'h8, 32'h00000020, '1, 0), 1, RES_DONE},
      '{mk(MODE_WRITE, 18'hc, 32'h0000bc05, '1, 0), 1, RES_DONE},
      '{mk(MODE_RENDER, 0, 0, 0, 9'd1), 0, RES_DONE},
      '{mk(MODE_WRITE, 18'hffc, 32'h7fff00ff, '1, 0), 1, RES_DONE},
      '{mk(MODE_RENDER, 0, 0, 0, 9'd511), 0, RES_DONE},
      '{mk(MODE_READ, 18'hffc, 0, 0, 0), 1, '{32'h7fff00ff, 0, 0, 0, 0, 0, 0, 0, 1}},
      '{mk(MODE_READ, 18'h10000, 0, 0, 0), 0, RES_DONE}
    };
    foreach (vectors[i]) send_item(vectors[i].item, vectors[i].typed, vectors[i].want);

    random_phase(70);
    set_frame(1, 4095, 4095, 1);
    send_idle_pct = 60;
    random_phase(60);
    set_frame(1, 1, 4095, 4095);
    send_idle_pct = 0; pop_stall_pct = 60;
    random_phase(60);
    set_frame(1, 200, 100, 150);
    send_idle_pct = 9; pop_stall_pct = 9;
    random_phase(70);
    set_frame(0, 640, 1, 320);
    send_idle_pct = 0; pop_stall_pct = 0;
    random_phase(40);

    drain();
    if (fail_count == 0) begin
      $display("** sprite_overlay_engine: PASSED **");
    end else begin
      $display("** sprite_overlay_engine: FAILED **");
    end
    $finish;
  end

endmodule
